FILE: rtl/core/wurm_pkg.sv
`timescale 1ns / 1ps
// Package with the types, sizes and codes shared by the usage rate meter files.
package wurm_pkg;

  localparam int SLOTS   = 64;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int COUNT_W = $clog2(SLOTS + 1);

  localparam int TIME_W  = 48;
  localparam int TOTAL_W = 40;
  localparam int RATE_W  = 62;
  localparam int CFG_W   = 48;

  // Stored totals are never negative, so an increase fits one bit less.
  localparam int USED_W    = TOTAL_W - 1;
  localparam int HOUR_W    = 22;
  localparam logic [HOUR_W-1:0] MS_PER_HOUR = 22'd3600000;
  localparam int MUL_SPLIT = 20;
  localparam int MUL_A_W   = (MUL_SPLIT > USED_W - MUL_SPLIT) ? MUL_SPLIT : USED_W - MUL_SPLIT;
  localparam int DVD_W     = USED_W + HOUR_W;
  localparam int DIV_CNT_W = $clog2(DVD_W);

  localparam logic CFG_WINDOW   = 1'b0;
  localparam logic CFG_MIN_SPAN = 1'b1;

  localparam logic ACT_OBSERVE = 1'b0;
  localparam logic ACT_QUERY   = 1'b1;

  localparam logic [CFG_W-1:0] WINDOW_RESET   = 48'd600000;
  localparam logic [CFG_W-1:0] MIN_SPAN_RESET = 48'd60000;

  typedef struct packed {
    logic                      action;
    logic [TIME_W-1:0]         now_ms;
    logic signed [TOTAL_W-1:0] usage_total;
  } cmd_t;

  typedef struct packed {
    logic              rate_valid;
    logic [RATE_W-1:0] rate_per_hour;
  } result_t;

endpackage

FILE: rtl/core/wurm_div.sv
`timescale 1ns / 1ps
// Restoring divider that retires one quotient bit per cycle.
module wurm_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [wurm_pkg::DVD_W-1:0]   dividend,
  input  logic [wurm_pkg::TIME_W-1:0]  divisor,
  output logic                         done,
  output logic [wurm_pkg::DVD_W-1:0]   quotient
);
  import wurm_pkg::*;

  logic                 active;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W-1:0]    dvs;
  logic [TIME_W-1:0]    rem;
  logic [DVD_W-1:0]     work;
  logic [TIME_W:0]      trial;
  logic [TIME_W:0]      diff;
  logic                 fits;

  // The remainder stays below the divisor, so the shifted trial fits one extra bit.
  always_comb begin
    trial = {rem, work[DVD_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= DIV_CNT_W'(DVD_W - 1);
      end else if (active) begin
        if (cnt == '0) begin
          active <= 1'b0;
          done   <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Dividend bits shift out at the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      work <= dividend;
      dvs  <= divisor;
    end else if (active) begin
      rem  <= fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
      work <= {work[DVD_W-2:0], fits};
    end
  end

  assign quotient = work;

endmodule

FILE: rtl/core/windowed_usage_rate_meter.sv
`timescale 1ns / 1ps
// Top level of the windowed usage rate meter: reading ring, walk sequencer and rate math.
//
// The meter keeps the last 64 timestamped cumulative usage readings in an on-chip
// memory and reports the usage increase per hour over a programmable look-back
// window. A word is taken when start is high and busy is low. An observe word
// gives no result. A query word walks the ring from the newest reading, one
// memory read per cycle, then forms the rate with a shared multiplier (two
// partial products) and a one-bit-per-cycle divider of 61 steps. Queries that
// are invalid from the start finish in the walk state, without the multiply
// and divide. The result is shown for exactly one cycle with done high and
// must be taken then. Configuration writes are accepted at any time but belong
// in idle periods. No clearing pass is needed after reset.
module windowed_usage_rate_meter (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  wurm_pkg::cmd_t              cmd,
  output logic                        done,
  output wurm_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [wurm_pkg::CFG_W-1:0]  cfg_data
);
  import wurm_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_OBS,
    S_WALK,
    S_FIN,
    S_CHK,
    S_MUL_LO,
    S_MUL_HI,
    S_MUL_ADD,
    S_DIV
  } state_t;

  state_t state;

  logic [TIME_W-1:0]  time_mem  [SLOTS];
  logic [TOTAL_W-1:0] total_mem [SLOTS];
  logic [TIME_W-1:0]  rd_time;
  logic [TOTAL_W-1:0] rd_total;
  logic [SLOT_W-1:0]  rd_addr;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;

  cmd_t                cmd_r;
  logic [SLOT_W-1:0]   write_slot;
  logic [COUNT_W-1:0]  stored_count;
  logic [CFG_W-1:0]    window_len;
  logic [CFG_W-1:0]    min_span;
  logic [SLOT_W-1:0]   walk_slot;
  logic [COUNT_W-1:0]  step;
  logic                found;
  logic                two;
  logic [TIME_W-1:0]   new_time;
  logic [TOTAL_W-1:0]  new_total;
  logic [TIME_W-1:0]   old_time;
  logic [TOTAL_W-1:0]  old_total;
  logic [TIME_W:0]     span;
  logic [TOTAL_W:0]    used;
  logic [MUL_SPLIT+HOUR_W-1:0]        prod_lo;
  logic [USED_W-MUL_SPLIT+HOUR_W-1:0] prod_hi;

  logic [SLOT_W-1:0]   last_slot;
  logic [SLOT_W-1:0]   walk_prev;
  logic [TOTAL_W-1:0]  obs_total;
  logic                obs_drop;
  logic                obs_clear;
  logic                too_old;
  logic                future;
  logic [MUL_A_W-1:0]  mul_a;
  logic [MUL_A_W+HOUR_W-1:0] mul_p;
  logic                div_start;
  logic [DVD_W-1:0]    dividend;
  logic                div_done;
  logic [DVD_W-1:0]    quotient;

  function automatic logic [SLOT_W-1:0] slot_prev(input logic [SLOT_W-1:0] s);
    return (s == '0) ? SLOT_W'(SLOTS - 1) : s - 1'b1;
  endfunction

  always_comb begin
    last_slot = slot_prev(write_slot);
    walk_prev = slot_prev(walk_slot);
    obs_total = cmd_r.usage_total;
    obs_drop  = obs_total[TOTAL_W-1] ||
                ((stored_count != '0) && (cmd_r.now_ms <= rd_time));
    obs_clear = (stored_count != '0) && (obs_total < rd_total);
    mem_we    = (state == S_OBS) && !obs_drop;
    mem_wa    = obs_clear ? '0 : write_slot;
    // A reading older than the window ends the walk; the sum cannot wrap at 49 bits.
    too_old   = ({1'b0, rd_time} + {1'b0, window_len}) < {1'b0, cmd_r.now_ms};
    future    = rd_time > cmd_r.now_ms;
    mul_a     = (state == S_MUL_LO) ? MUL_A_W'(used[MUL_SPLIT-1:0])
                                    : MUL_A_W'(used[USED_W-1:MUL_SPLIT]);
    mul_p     = mul_a * MS_PER_HOUR;
    div_start = (state == S_MUL_ADD);
    dividend  = DVD_W'(prod_lo) + {prod_hi, MUL_SPLIT'(0)};
    case (state)
      S_WALK:  rd_addr = walk_prev;
      default: rd_addr = last_slot;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      time_mem[mem_wa]  <= cmd_r.now_ms;
      total_mem[mem_wa] <= obs_total;
    end
    rd_time  <= time_mem[rd_addr];
    rd_total <= total_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WINDOW_RESET;
      min_span   <= MIN_SPAN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW:   window_len <= cfg_data;
        CFG_MIN_SPAN: min_span   <= cfg_data;
        default: ;
      endcase
    end
  end

  wurm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (span[TIME_W-1:0]),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      write_slot   <= '0;
      stored_count <= '0;
      done         <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= cmd;
            walk_slot <= last_slot;
            step      <= '0;
            found     <= 1'b0;
            two       <= 1'b0;
            state     <= (cmd.action == ACT_QUERY) ? S_WALK : S_OBS;
          end
        end
        S_OBS: begin
          if (!obs_drop) begin
            if (obs_clear) begin
              write_slot   <= (SLOTS == 1) ? '0 : SLOT_W'(1);
              stored_count <= COUNT_W'(1);
            end else begin
              write_slot <= (write_slot == SLOT_W'(SLOTS - 1)) ? '0 : write_slot + 1'b1;
              if (stored_count != COUNT_W'(SLOTS)) begin
                stored_count <= stored_count + 1'b1;
              end
            end
          end
          state <= S_IDLE;
        end
        S_WALK: begin
          if ((stored_count < COUNT_W'(2)) || (window_len == '0)) begin
            done                 <= 1'b1;
            result.rate_valid    <= 1'b0;
            result.rate_per_hour <= '0;
            state                <= S_IDLE;
          end else if ((step == stored_count) || too_old) begin
            state <= S_FIN;
          end else begin
            walk_slot <= walk_prev;
            step      <= step + 1'b1;
            if (!future) begin
              if (!found) begin
                new_time  <= rd_time;
                new_total <= rd_total;
              end
              found     <= 1'b1;
              two       <= found;
              old_time  <= rd_time;
              old_total <= rd_total;
            end
          end
        end
        S_FIN: begin
          span <= {1'b0, new_time} - {1'b0, old_time};
          used <= {1'b0, new_total} - {1'b0, old_total};
          if (!two) begin
            done                 <= 1'b1;
            result.rate_valid    <= 1'b0;
            result.rate_per_hour <= '0;
            state                <= S_IDLE;
          end else begin
            state <= S_CHK;
          end
        end
        S_CHK: begin
          if (span[TIME_W] || (span == '0) || (span[TIME_W-1:0] < min_span)) begin
            done                 <= 1'b1;
            result.rate_valid    <= 1'b0;
            result.rate_per_hour <= '0;
            state                <= S_IDLE;
          end else if (used[TOTAL_W] || (used == '0)) begin
            done                 <= 1'b1;
            result.rate_valid    <= 1'b1;
            result.rate_per_hour <= '0;
            state                <= S_IDLE;
          end else begin
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          prod_lo <= (MUL_SPLIT + HOUR_W)'(mul_p);
          state   <= S_MUL_HI;
        end
        S_MUL_HI: begin
          prod_hi <= (USED_W - MUL_SPLIT + HOUR_W)'(mul_p);
          state   <= S_MUL_ADD;
        end
        S_MUL_ADD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          // The quotient is below 2^61, so it never reaches the field maximum.
          if (div_done) begin
            done                 <= 1'b1;
            result.rate_valid    <= 1'b1;
            result.rate_per_hour <= RATE_W'(quotient);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: rtl/core/wurm_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the usage rate meter and the bind that attaches it.
module wurm_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input wurm_pkg::cmd_t      cmd,
  input logic                done,
  input wurm_pkg::result_t   result
);
  import wurm_pkg::*;

  // A result only follows a word that kept the block busy.
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a busy cycle before it");

  // An observe word never produces a result.
  a_observe_silent: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.action == ACT_OBSERVE)) |=> !done ##1 !done)
    else $error("observe word produced a result");

  // An invalid rate always carries a zero value.
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.rate_valid) |-> (result.rate_per_hour == '0))
    else $error("invalid result with nonzero rate");

  // A query makes the block busy, with no result, in the cycle after it is taken.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.action == ACT_QUERY)) |=> (busy && !done))
    else $error("query word did not make the block busy");

  // Results never come in consecutive cycles.
  a_single_strobe: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for two cycles");

endmodule

bind windowed_usage_rate_meter wurm_checker u_wurm_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .cmd    (cmd),
  .done   (done),
  .result (result)
);

FILE: bench/windowed_usage_rate_meter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the windowed usage rate meter with its own rate predictor.
module windowed_usage_rate_meter_tb;
  import wurm_pkg::*;

  localparam logic [TIME_W-1:0] TIME_MAX  = '1;
  localparam logic [63:0]       TOTAL_MAX = 64'h7F_FFFF_FFFF;
  localparam logic [63:0]       HOUR_MS   = 64'd3600000;
  localparam logic [63:0]       RATE_TOP  = {2'b00, {RATE_W{1'b1}}};
  localparam int                RING      = 64;

  typedef struct packed {
    logic              is_reg;
    logic              reg_idx;
    logic [CFG_W-1:0]  reg_val;
    cmd_t              word;
    logic              typed;
    result_t           typed_rate;
  } plan_row_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic             busy;
  cmd_t             cmd = '0;
  logic             done;
  result_t          result;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_WINDOW;
  logic [CFG_W-1:0] cfg_data = '0;

  // Shadow copy of the reading ring and the registers.
  logic [TIME_W-1:0]  hist_time [RING];
  logic [TOTAL_W-1:0] hist_total [RING];
  logic [5:0]         next_slot = '0;
  int                 n_stored = 0;
  logic [CFG_W-1:0]   win_ms = WINDOW_RESET;
  logic [CFG_W-1:0]   span_floor_ms = MIN_SPAN_RESET;

  result_t pending_rates [$];
  result_t want_rate;
  int      mismatches = 0;

  always #5 clk = ~clk;

  windowed_usage_rate_meter dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .done      (done),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic void note_reading(logic [TIME_W-1:0] t, logic [TOTAL_W-1:0] tot);
    logic [5:0] last;
    if (tot[TOTAL_W-1]) return;
    if (n_stored > 0) begin
      last = next_slot - 6'd1;
      if (t <= hist_time[last]) return;
      // A falling total means the counter restarted, so the history goes.
      if (tot < hist_total[last]) begin
        n_stored  = 0;
        next_slot = '0;
      end
    end
    hist_time[next_slot]  = t;
    hist_total[next_slot] = tot;
    next_slot = next_slot + 6'd1;
    if (n_stored < RING) n_stored++;
  endfunction

  function automatic result_t rate_for(logic [TIME_W-1:0] now);
    result_t    r;
    logic [5:0] s;
    logic [5:0] newest;
    logic [5:0] oldest;
    bit         found;
    logic [63:0] span;
    logic [63:0] used;
    logic [63:0] q;
    r = '0;
    found = 1'b0;
    newest = '0;
    oldest = '0;
    if (n_stored < 2 || win_ms == '0) return r;
    for (int i = 0; i < n_stored; i++) begin
      s = next_slot - 6'd1 - i[5:0];
      if ({16'd0, hist_time[s]} + {16'd0, win_ms} < {16'd0, now}) break;
      if (hist_time[s] > now) continue;
      if (!found) begin
        newest = s;
        found = 1'b1;
      end
      oldest = s;
    end
    if (!found || oldest == newest) return r;
    if (hist_time[newest] <= hist_time[oldest]) return r;
    span = {16'd0, hist_time[newest]} - {16'd0, hist_time[oldest]};
    if (span < {16'd0, span_floor_ms}) return r;
    r.rate_valid = 1'b1;
    if (hist_total[newest] <= hist_total[oldest]) return r;
    used = {24'd0, hist_total[newest]} - {24'd0, hist_total[oldest]};
    q = (used * HOUR_MS) / span;
    r.rate_per_hour = (q > RATE_TOP) ? RATE_TOP[RATE_W-1:0] : q[RATE_W-1:0];
    return r;
  endfunction

  function automatic plan_row_t obs_row(logic [TIME_W-1:0] t, logic [TOTAL_W-1:0] tot);
    plan_row_t r;
    r = '0;
    r.word.action      = ACT_OBSERVE;
    r.word.now_ms      = t;
    r.word.usage_total = tot;
    return r;
  endfunction

  function automatic plan_row_t query_row(logic [TIME_W-1:0] t);
    plan_row_t r;
    r = '0;
    r.word.action = ACT_QUERY;
    r.word.now_ms = t;
    return r;
  endfunction

  function automatic plan_row_t checked_query(logic [TIME_W-1:0] t, logic ok,
                                              logic [RATE_W-1:0] rate);
    plan_row_t r;
    r = query_row(t);
    r.typed = 1'b1;
    r.typed_rate.rate_valid    = ok;
    r.typed_rate.rate_per_hour = rate;
    return r;
  endfunction

  function automatic plan_row_t reg_row(logic idx, logic [CFG_W-1:0] val);
    plan_row_t r;
    r = '0;
    r.is_reg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Mostly well-formed readings that climb from the newest stored one, queries
  // near the newest time, and some noise that the block must drop or treat as
  // a counter restart.
  function automatic plan_row_t random_row(int unsigned pace);
    plan_row_t   r;
    logic [63:0] base_t;
    logic [63:0] base_tot;
    logic [63:0] t;
    logic [63:0] tot;
    logic [63:0] back;
    int          pick;
    r = '0;
    base_t   = (n_stored > 0) ? {16'd0, hist_time[next_slot - 6'd1]} : 64'd0;
    base_tot = (n_stored > 0) ? {24'd0, hist_total[next_slot - 6'd1]} : 64'd0;
    pick = $urandom_range(0, 99);
    r.word.action = ACT_OBSERVE;
    t   = base_t + 64'($urandom_range(1, pace));
    tot = base_tot;
    if (pick < 55) begin
      if ($urandom_range(0, 29) == 0) tot = TOTAL_MAX - 64'($urandom_range(0, 1000));
      else if ($urandom_range(0, 3) != 0)
        tot = base_tot + 64'($urandom & ((32'd1 << $urandom_range(0, 24)) - 32'd1));
      if (tot > TOTAL_MAX) tot = 64'($urandom_range(0, 1000));
    end else if (pick < 85) begin
      r.word.action = ACT_QUERY;
      tot = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: t = base_t + 64'($urandom_range(0, pace));
        6, 7: begin
          back = 64'($urandom_range(0, 4 * pace));
          t = (back > base_t) ? 64'd0 : base_t - back;
        end
        8: t = base_t + {16'd0, win_ms} + 64'($urandom_range(1, pace));
        default: t = {$urandom, $urandom};
      endcase
    end else begin
      case ($urandom_range(0, 3))
        0: tot = {$urandom, $urandom} | (64'd1 << (TOTAL_W - 1));
        1: begin
          back = 64'($urandom_range(0, pace));
          t = (back > base_t) ? 64'd0 : base_t - back;
        end
        2: tot = (base_tot == 0) ? 64'd0 : {$urandom, $urandom} % base_tot;
        default: begin
          t   = {$urandom, $urandom} % (base_t + 64'(pace) + 64'd1);
          tot = {$urandom, $urandom} & TOTAL_MAX;
        end
      endcase
    end
    r.word.now_ms      = t[TIME_W-1:0];
    r.word.usage_total = tot[TOTAL_W-1:0];
    return r;
  endfunction

  // Offers one word, waits for it to be taken, then records what it must cause.
  task automatic send_word(plan_row_t r, int gap);
    start <= 1'b1;
    cmd   <= r.word;
    do @(posedge clk); while (busy);
    if (r.word.action == ACT_QUERY)
      pending_rates.push_back(r.typed ? r.typed_rate : rate_for(r.word.now_ms));
    else
      note_reading(r.word.now_ms, r.word.usage_total);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Observes give no result, so the wait after the last result also covers one still in flight.
  task automatic settle();
    start <= 1'b0;
    while (pending_rates.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [CFG_W-1:0] val);
    settle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_WINDOW) win_ms = val;
    else span_floor_ms = val;
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_rates.size() == 0) begin
        $error("rate word with none expected: valid %0d rate %0d",
               result.rate_valid, result.rate_per_hour);
        mismatches++;
      end else begin
        want_rate = pending_rates.pop_front();
        if (result.rate_valid !== want_rate.rate_valid) begin
          $error("rate_valid: expected %0d, got %0d", want_rate.rate_valid, result.rate_valid);
          mismatches++;
        end
        if (result.rate_per_hour !== want_rate.rate_per_hour) begin
          $error("rate_per_hour: expected %0d, got %0d",
                 want_rate.rate_per_hour, result.rate_per_hour);
          mismatches++;
        end
      end
    end
  end

  initial begin
    plan_row_t   rows [$];
    bit          no_gaps;
    int unsigned pace;
    no_gaps = 1'b0;
    rows.push_back(checked_query(48'd0, 1'b0, '0));
    rows.push_back(obs_row(48'd0, 40'd100));
    rows.push_back(checked_query(48'd0, 1'b0, '0));
    rows.push_back(obs_row(48'd0, 40'd200));
    rows.push_back(obs_row(48'd2000, 40'hFF_FFFF_FFFF));
    rows.push_back(obs_row(48'd3000, 40'h80_0000_0000));
    rows.push_back(obs_row(48'd60000, 40'd1100));
    rows.push_back(checked_query(48'd60000, 1'b1, 62'd60000));
    rows.push_back(query_row(48'd30000));
    rows.push_back(obs_row(48'd200000, 40'd50));
    rows.push_back(obs_row(48'd300000, 40'd50));
    rows.push_back(checked_query(48'd300000, 1'b1, '0));
    rows.push_back(reg_row(CFG_WINDOW, '0));
    rows.push_back(checked_query(48'd300000, 1'b0, '0));
    rows.push_back(reg_row(CFG_WINDOW, TIME_MAX));
    rows.push_back(reg_row(CFG_MIN_SPAN, '0));
    rows.push_back(obs_row(48'd300001, TOTAL_MAX[TOTAL_W-1:0]));
    rows.push_back(query_row(TIME_MAX));
    rows.push_back(query_row(48'd300001));
    rows.push_back(reg_row(CFG_MIN_SPAN, TIME_MAX));
    rows.push_back(checked_query(TIME_MAX, 1'b0, '0));
    rows.push_back(reg_row(CFG_WINDOW, 48'd600000));
    rows.push_back(reg_row(CFG_MIN_SPAN, 48'd60000));
    rows.push_back(query_row(TIME_MAX));
    rows.push_back(query_row(48'd900001));

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_reg) write_reg(rows[i].reg_idx, rows[i].reg_val);
      else send_word(rows[i], $urandom_range(0, 18));
    end

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(CFG_WINDOW, TIME_MAX);
          write_reg(CFG_MIN_SPAN, '0);
        end
        1: begin
          write_reg(CFG_WINDOW, '0);
          write_reg(CFG_MIN_SPAN, CFG_W'($urandom_range(0, 100000)));
        end
        2: begin
          write_reg(CFG_WINDOW, CFG_W'($urandom_range(1, 31)));
          write_reg(CFG_MIN_SPAN, '0);
        end
        3: begin
          write_reg(CFG_WINDOW, CFG_W'($urandom_range(2000, 1 << 22)));
          write_reg(CFG_MIN_SPAN, TIME_MAX);
        end
        default: begin
          write_reg(CFG_WINDOW, CFG_W'($urandom_range(2000, 1 << 22)));
          write_reg(CFG_MIN_SPAN, CFG_W'($urandom_range(0, win_ms[31:0] / 4)));
        end
      endcase
      // Small steps against the window keep recent readings inside it, but not always the whole ring.
      if (win_ms == '0 || win_ms > (48'd1 << 24)) pace = $urandom_range(1, 1 << 20);
      else pace = win_ms[31:0] / $urandom_range(8, 96) + 1;
      for (int k = 0; k < 160; k++) begin
        if (k % 32 == 0) no_gaps = ($urandom_range(0, 2) == 0);
        send_word(random_row(pace), no_gaps ? 0 : $urandom_range(0, 18));
      end
    end

    settle();
    repeat (150) @(posedge clk);
    if (mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/wurm_pkg.sv
rtl/core/wurm_div.sv
rtl/core/windowed_usage_rate_meter.sv
rtl/core/wurm_checker.sv
bench/windowed_usage_rate_meter_tb.sv
